// ----- rtl/core/hlpf_pkg.sv -----
package hlpf_pkg;

  localparam int unsigned ACC_W      = 32;
  localparam int unsigned PIX_W      = 16;
  localparam int unsigned DIM_W      = 9;
  localparam int unsigned MAX_DIM    = 256;
  localparam int unsigned ANGLES     = 180;
  localparam int unsigned ACC_ROWS   = 2 * MAX_DIM + 1;
  localparam int unsigned ACC_CELLS  = ACC_ROWS * ANGLES;
  localparam int unsigned ADDR_W     = $clog2(ACC_CELLS);
  localparam int unsigned ROW_W      = $clog2(ACC_ROWS);
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned SQ_W       = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CROSS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd5;

  localparam logic [14:0] SIN_TAB [91] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
    15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
    15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
    15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
    15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
    15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  typedef struct packed {
    logic clear_start;
    logic sqrt_start;
    logic pix_accept;
    logic vote_start;
    logic search_start;
    logic fin_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic dirty;
    logic sqrt_busy;
    logic sweep_busy;
    logic votes;
    logic last;
    logic fin_rdy;
    logic out_full;
  } sts_t;

  typedef struct packed {
    logic [ACC_W-1:0]  value;
    logic signed [18:0] y_q8;
    logic signed [18:0] x_q8;
    logic signed [8:0]  radius;
    logic [7:0]         angle;
  } result_t;

  function automatic logic signed [15:0] sin_q14(input logic [7:0] a);
    logic [7:0] k;
    k = (a <= 8'd90) ? a : 8'd180 - a;
    return $signed({1'b0, SIN_TAB[k[6:0]]});
  endfunction

  function automatic logic signed [15:0] cos_q14(input logic [7:0] a);
    logic [7:0] k;
    k = (a <= 8'd90) ? 8'd90 - a : a - 8'd90;
    return (a <= 8'd90) ? $signed({1'b0, SIN_TAB[k[6:0]]})
                        : -$signed({1'b0, SIN_TAB[k[6:0]]});
  endfunction

  function automatic logic [10:0] abs11(input logic signed [10:0] v);
    return v[10] ? 11'(-v) : 11'(v);
  endfunction

endpackage

// ----- rtl/core/hlpf_isqrt.sv -----
module hlpf_isqrt import hlpf_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [SQ_W-1:0] n_i,
  output logic            busy_o,
  output logic [8:0]      root_o
);

  logic [SQ_W-1:0] rem_q, rem_d, res_q, res_d, bit_q, bit_d, trial;

  // Classic digit-by-digit square root, one result bit per cycle.
  always_comb begin
    rem_d = rem_q;
    res_d = res_q;
    bit_d = bit_q;
    trial = res_q + bit_q;
    if (start_i) begin
      rem_d = n_i;
      res_d = '0;
      bit_d = SQ_W'(1) << 16;
    end else if (bit_q != '0) begin
      if (rem_q >= trial) begin
        rem_d = rem_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      res_q <= '0;
      bit_q <= '0;
    end else begin
      rem_q <= rem_d;
      res_q <= res_d;
      bit_q <= bit_d;
    end
  end

  assign busy_o = (bit_q != '0);
  assign root_o = res_q[8:0];

endmodule

// ----- rtl/core/hlpf_dp.sv -----
module hlpf_dp import hlpf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [PIX_W-1:0]      pix_i,
  input  logic                  last_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  output result_t               res_o,
  output logic                  res_valid_o,
  input  logic                  res_ready_i
);

  localparam logic [1:0] MD_VOTE = 2'd0;
  localparam logic [1:0] MD_SRCH = 2'd1;
  localparam logic [1:0] MD_CLR  = 2'd2;

  // Configuration registers.
  logic [15:0]      thr_q;
  logic signed [9:0] base_q;
  logic [8:0]       range_q;
  logic             cross_q;
  logic [DIM_W-1:0] wcfg_q, hcfg_q;
  logic             dirty_q;
  logic [DIM_W-1:0] weff, heff;
  logic [7:0]       cx, cy, rmax;
  logic [8:0]       root;
  logic             sq_busy;
  logic [SQ_W-1:0]  sq_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= '0;
      base_q  <= 10'sd90;
      range_q <= 9'd180;
      cross_q <= 1'b0;
      wcfg_q  <= 9'd256;
      hcfg_q  <= 9'd256;
      dirty_q <= 1'b1;
    end else begin
      if (cmd_i.sqrt_start) dirty_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_THRESHOLD: thr_q   <= cfg_data_i;
          CFG_BASE:      base_q  <= $signed(cfg_data_i[9:0]);
          CFG_RANGE:     range_q <= cfg_data_i[8:0];
          CFG_CROSS:     cross_q <= cfg_data_i[0];
          CFG_WIDTH: begin
            wcfg_q  <= cfg_data_i[8:0];
            dirty_q <= 1'b1;
          end
          CFG_HEIGHT: begin
            hcfg_q  <= cfg_data_i[8:0];
            dirty_q <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  assign weff = (wcfg_q == '0) ? 9'd1 : (wcfg_q > 9'(MAX_DIM)) ? 9'(MAX_DIM) : wcfg_q;
  assign heff = (hcfg_q == '0) ? 9'd1 : (hcfg_q > 9'(MAX_DIM)) ? 9'(MAX_DIM) : hcfg_q;
  assign cx   = weff[8:1];
  assign cy   = heff[8:1];
  assign sq_n = SQ_W'(weff) * SQ_W'(weff) + SQ_W'(heff) * SQ_W'(heff);
  assign rmax = root[8:1];

  hlpf_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .n_i     (sq_n),
    .busy_o  (sq_busy),
    .root_o  (root)
  );

  // Pixel position and the vote decision.
  logic [7:0]        col_q;
  logic [8:0]        row_q;
  logic              votes_q, last_q, up_q;
  logic [PIX_W-1:0]  pix_q;
  logic signed [9:0] dx_q, dy_q;
  logic [8:0]        col1;
  logic [11:0]       c10, r10;
  logic              vote_d;

  always_comb begin
    c10    = 12'(col_q) * 12'd10;
    r10    = 12'(row_q) * 12'd10;
    col1   = {1'b0, col_q} + 9'd1;
    vote_d = ({1'b0, col_q} < weff) && (row_q < heff) &&
             (12'(heff) < r10 + 12'd10) && (r10 < 12'(heff) * 12'd9) &&
             (12'(weff) < c10 + 12'd10) && (c10 < 12'(weff) * 12'd9) &&
             (pix_i >= thr_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      votes_q <= 1'b0;
      last_q  <= 1'b0;
    end else if (cmd_i.pix_accept) begin
      votes_q <= vote_d;
      last_q  <= last_i;
      if (last_i) begin
        col_q <= '0;
        row_q <= '0;
      end else if (col1 >= weff) begin
        col_q <= '0;
        if (row_q < heff) row_q <= row_q + 9'd1;
      end else begin
        col_q <= col1[7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_accept) begin
      pix_q <= pix_i;
      up_q  <= cross_q && (row_q < {1'b0, cy});
      dx_q  <= $signed({2'b0, col_q}) - $signed({2'b0, cx});
      dy_q  <= $signed({1'b0, row_q}) - $signed({2'b0, cy});
    end
  end

  // Sweep sequencer shared by voting, search and clearing.
  logic              act_q;
  logic [1:0]        mode_q;
  logic [7:0]        o_q;
  logic [ADDR_W-1:0] addr_q;
  logic [ROW_W-1:0]  j_q;
  logic [7:0]        i_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      mode_q <= MD_VOTE;
      o_q    <= '0;
      addr_q <= '0;
      j_q    <= '0;
      i_q    <= '0;
    end else if (cmd_i.vote_start) begin
      act_q  <= 1'b1;
      mode_q <= MD_VOTE;
      o_q    <= '0;
    end else if (cmd_i.search_start || cmd_i.clear_start) begin
      act_q  <= 1'b1;
      mode_q <= cmd_i.search_start ? MD_SRCH : MD_CLR;
      addr_q <= '0;
      j_q    <= '0;
      i_q    <= '0;
    end else if (act_q) begin
      if (mode_q == MD_VOTE) begin
        if (o_q == 8'(ANGLES - 1)) act_q <= 1'b0;
        o_q <= o_q + 8'd1;
      end else begin
        if (addr_q == ADDR_W'(ACC_CELLS - 1)) act_q <= 1'b0;
        addr_q <= addr_q + ADDR_W'(1);
        if (i_q == 8'(ANGLES - 1)) begin
          i_q <= '0;
          j_q <= j_q + ROW_W'(1);
        end else begin
          i_q <= i_q + 8'd1;
        end
      end
    end
  end

  // Vote pipeline: window and trig, products, radius, address and read, write.
  logic               v1_q, v2_q, v3_q, v4_q;
  logic [7:0]         o1_q, o2_q, o3_q;
  logic signed [15:0] s1_q, c1_q;
  logic signed [25:0] ps2_q, pc2_q;
  logic [ROW_W-1:0]   idx3_q;
  logic [ADDR_W-1:0]  addr4_q;
  logic signed [10:0] dd;
  logic [10:0]        d1, d2, d3, dmin;
  logic               win_ok;
  logic signed [26:0] vsum, vq, vidx;
  logic               idx_ok;
  logic [ADDR_W-1:0]  vaddr;

  always_comb begin
    dd     = $signed({3'b0, o_q}) - 11'(base_q);
    d1     = abs11(dd);
    d2     = abs11(dd + 11'sd180);
    d3     = abs11(dd - 11'sd180);
    dmin   = (d2 < d1) ? d2 : d1;
    dmin   = (d3 < dmin) ? d3 : dmin;
    win_ok = dmin < {2'b0, range_q};
    vsum   = 27'(ps2_q) + 27'(pc2_q);
    vq     = vsum >>> 14;
    if (vsum[26] && (vsum[13:0] != '0)) vq = vq + 27'sd1;
    vidx   = vq + $signed({19'b0, rmax});
    idx_ok = !vidx[26] && (vidx <= $signed({18'b0, rmax, 1'b0}));
    vaddr  = ADDR_W'(idx3_q) * ADDR_W'(ANGLES) + ADDR_W'(o3_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= act_q && (mode_q == MD_VOTE) && win_ok;
      v2_q <= v1_q;
      v3_q <= v2_q && idx_ok;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    o1_q    <= o_q;
    s1_q    <= sin_q14(o_q);
    c1_q    <= cos_q14(o_q);
    o2_q    <= o1_q;
    ps2_q   <= dx_q * s1_q;
    pc2_q   <= dy_q * c1_q;
    o3_q    <= o2_q;
    idx3_q  <= vidx[ROW_W-1:0];
    addr4_q <= vaddr;
  end

  // Search pipeline: read, then compare and clear behind the read.
  logic              sv1_q, inr1_q;
  logic [ADDR_W-1:0] addr1_q;
  logic [ROW_W-1:0]  j1_q, bj_q;
  logic [7:0]        i1_q, bi_q;
  logic [ACC_W-1:0]  best_q, cand;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sv1_q <= 1'b0;
    else         sv1_q <= act_q && (mode_q == MD_SRCH);
  end

  // Accumulator stores with registered read data.
  logic [ACC_W-1:0]  main_mem [ACC_CELLS];
  logic [ACC_W-1:0]  up_mem   [ACC_CELLS];
  logic [ACC_W-1:0]  main_rd_q, up_rd_q, wdata, acc_rd;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              main_we, up_we;
  logic [ACC_W:0]    acc_sum;

  always_comb begin
    rd_addr = (mode_q == MD_VOTE) ? vaddr : addr_q;
    acc_rd  = up_q ? up_rd_q : main_rd_q;
    acc_sum = {1'b0, acc_rd} + (ACC_W + 1)'(pix_q);
    cand    = (cross_q && (up_rd_q < main_rd_q)) ? up_rd_q : main_rd_q;
    wdata   = '0;
    main_we = 1'b0;
    up_we   = 1'b0;
    wr_addr = addr_q;
    priority if (v4_q) begin
      wr_addr = addr4_q;
      wdata   = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
      main_we = !up_q;
      up_we   = up_q;
    end else if (sv1_q) begin
      wr_addr = addr1_q;
      main_we = 1'b1;
      up_we   = 1'b1;
    end else if (act_q && (mode_q == MD_CLR)) begin
      main_we = 1'b1;
      up_we   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (main_we) main_mem[wr_addr] <= wdata;
    main_rd_q <= main_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (up_we) up_mem[wr_addr] <= wdata;
    up_rd_q <= up_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    addr1_q <= addr_q;
    j1_q    <= j_q;
    i1_q    <= i_q;
    inr1_q  <= j_q <= {1'b0, rmax, 1'b0};
    if (cmd_i.search_start) begin
      best_q <= '0;
      bi_q   <= '0;
      bj_q   <= '0;
    end else if (sv1_q && inr1_q && (cand > best_q)) begin
      best_q <= cand;
      bi_q   <= i1_q;
      bj_q   <= j1_q;
    end
  end

  // Peak point: trig lookup, products, rounding to Q.8.
  logic               f1_q, f2_q, fin_rdy_q;
  logic signed [10:0] rad_q;
  logic signed [15:0] fs_q, fc_q;
  logic signed [26:0] px_q, py_q, xr, yr;
  logic [18:0]        x_q, y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_q      <= 1'b0;
      f2_q      <= 1'b0;
      fin_rdy_q <= 1'b0;
    end else begin
      f1_q <= cmd_i.fin_start;
      f2_q <= f1_q;
      if (f2_q) fin_rdy_q <= 1'b1;
      else if (cmd_i.out_load) fin_rdy_q <= 1'b0;
    end
  end

  always_comb begin
    xr = $signed({11'b0, cx, 8'b0}) + ((px_q + 27'sd32) >>> 6);
    yr = $signed({11'b0, cy, 8'b0}) + ((py_q + 27'sd32) >>> 6);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_start) begin
      rad_q <= $signed({1'b0, bj_q}) - $signed({3'b0, rmax});
      fs_q  <= sin_q14(bi_q);
      fc_q  <= cos_q14(bi_q);
    end
    px_q <= rad_q * fs_q;
    py_q <= rad_q * fc_q;
    if (f2_q) begin
      x_q <= xr[18:0];
      y_q <= yr[18:0];
    end
  end

  // Output register.
  logic    ov_q;
  result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (cmd_i.out_load) ov_q <= 1'b1;
    else if (res_ready_i) ov_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_q.value  <= best_q;
      res_q.angle  <= bi_q;
      res_q.radius <= rad_q[8:0];
      res_q.x_q8   <= $signed(x_q);
      res_q.y_q8   <= $signed(y_q);
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = ov_q;

  assign sts_o.dirty      = dirty_q;
  assign sts_o.sqrt_busy  = sq_busy;
  assign sts_o.sweep_busy = act_q | v1_q | v2_q | v3_q | v4_q | sv1_q;
  assign sts_o.votes      = votes_q;
  assign sts_o.last       = last_q;
  assign sts_o.fin_rdy    = fin_rdy_q;
  assign sts_o.out_full   = ov_q && !res_ready_i;

endmodule

// ----- rtl/core/hlpf_ctrl.sv -----
module hlpf_ctrl import hlpf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_CLEAR  = 3'd1;
  localparam logic [2:0] ST_IDLE   = 3'd2;
  localparam logic [2:0] ST_SQRT   = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;
  localparam logic [2:0] ST_VOTE   = 3'd5;
  localparam logic [2:0] ST_SEARCH = 3'd6;
  localparam logic [2:0] ST_FIN    = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.clear_start = 1'b1;
        state_d = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (!sts_i.sweep_busy) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (sts_i.dirty) begin
          cmd_o.sqrt_start = 1'b1;
          state_d = ST_SQRT;
        end else begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            cmd_o.pix_accept = 1'b1;
            state_d = ST_DECIDE;
          end
        end
      end
      ST_SQRT: begin
        if (!sts_i.sqrt_busy) state_d = ST_IDLE;
      end
      ST_DECIDE: begin
        if (sts_i.votes) begin
          cmd_o.vote_start = 1'b1;
          state_d = ST_VOTE;
        end else if (sts_i.last) begin
          cmd_o.search_start = 1'b1;
          state_d = ST_SEARCH;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_VOTE: begin
        if (!sts_i.sweep_busy) begin
          if (sts_i.last) begin
            cmd_o.search_start = 1'b1;
            state_d = ST_SEARCH;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SEARCH: begin
        if (!sts_i.sweep_busy) begin
          cmd_o.fin_start = 1'b1;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts_i.fin_rdy && !sts_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_INIT;
    else         state_q <= state_d;
  end

  // A pixel is only taken once the previous sweep has drained.
  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !sts_i.sweep_busy && !sts_i.sqrt_busy)
    else $error("pixel taken while the datapath is busy");

  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.fin_rdy && !sts_i.out_full)
    else $error("result loaded before it was ready or over a pending one");

  a_one_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.vote_start, cmd_o.search_start, cmd_o.clear_start}))
    else $error("two sweeps started together");

  a_sweep_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.vote_start || cmd_o.search_start) |-> !sts_i.sweep_busy)
    else $error("sweep started over a running one");

endmodule

// ----- rtl/core/hough_line_peak_finder_unit.sv -----
// Channel   Direction  Beat contents
// s_axis    in         tdata[15:0] pixel_value; tlast = last pixel of the frame
// m_axis    out        tdata: angle, radius, x_q8, y_q8, value (one beat per frame)
// cfg       in         write enable, register index, write data; no read-back
//
// A voting pixel takes 180 angle steps, with one read-modify-write for each angle in
// the window on the accumulator store that it votes into, then drains the vote
// pipeline and is handed off. The last pixel adds a peak search over all 92340
// cells (one per cycle). After reset a clearing pass over all 92340 cells runs
// before the first pixel, and each frame size change stalls the input while the
// square root of the new diagonal runs its 9 steps.
// A waiting result does not block the next frame until its own peak is ready.
module hough_line_peak_finder_unit import hlpf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,  // pixel_value
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // best_angle_deg[7:0], peak radius[16:8], best_x_q8[35:17],
  // best_y_q8[54:36], best_value[86:55], zero pad [87]
  output logic [87:0]           m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t    cmd;
  sts_t    sts;
  result_t res;

  // The controller sequences clear, sqrt, vote, search and readout; the
  // datapath owns the stores, counters and arithmetic.
  hlpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hlpf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pix_i       (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {1'b0, res.value, res.y_q8, res.x_q8, res.radius, res.angle};

endmodule
